>>> rtl/srv_pkg.sv
// package of the reverb block: item types, constants, gain tables and the microcode program
`default_nettype none
package srv_pkg;

  localparam int NUM_STAGES    = 6;
  localparam int NUM_COMB      = 4;
  localparam int MAX_DELAY_DEF = 4096;
  localparam int DLY_W         = 13;
  localparam int SMP_W         = 16;
  localparam int STG_W         = 3;
  localparam int PC_W          = 4;
  localparam int ACC_W         = 32;
  localparam int FRAC_W        = 15;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_in;
    logic                    last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_out;
    logic                    clipped;
    logic                    last_out;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL,
    OP_WB
  } op_e;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_IN,
    COND_OUT
  } cond_e;

  // one control word of the program
  typedef struct packed {
    op_e              op;
    logic [STG_W-1:0] stage;
    logic             rd;
    logic [STG_W-1:0] rd_stage;
    cond_e            cond;
    logic             emit;
    logic             jmp0;
  } uword_t;

  // strobes from the sequencer to the datapath, already qualified
  typedef struct packed {
    logic             load;
    logic             mul;
    logic             wb;
    logic             emit;
    logic             rd;
    logic [STG_W-1:0] stage;
    logic [STG_W-1:0] rd_stage;
  } ctrl_t;

  typedef struct packed {
    logic clr_busy;
    logic out_free;
  } sts_t;

  function automatic logic [DLY_W-1:0] dly_reset(logic [STG_W-1:0] k);
    logic [DLY_W-1:0] r;
    case (k)
      3'd0:    r = 13'd1309;
      3'd1:    r = 13'd793;
      3'd2:    r = 13'd1984;
      3'd3:    r = 13'd2646;
      3'd4:    r = 13'd220;
      3'd5:    r = 13'd74;
      default: r = 13'd1;
    endcase
    return r;
  endfunction

  // q1.15 gain on the delayed sample
  function automatic logic [15:0] gain_d(logic [STG_W-1:0] k);
    logic [15:0] g;
    case (k)
      3'd0:    g = 16'd26378;
      3'd1:    g = 16'd27099;
      3'd2:    g = 16'd25657;
      3'd3:    g = 16'd25035;
      default: g = 16'd22938;
    endcase
    return g;
  endfunction

  // q1.15 gain on the stage input: unity for combs, one minus g for all-passes
  function automatic logic [15:0] gain_x(logic [STG_W-1:0] k);
    logic [15:0] g;
    if (k < STG_W'(NUM_COMB)) begin
      g = 16'd32768;
    end else begin
      g = 16'd9830;
    end
    return g;
  endfunction

  function automatic uword_t mk(op_e op, logic [STG_W-1:0] stage, logic rd,
                                logic [STG_W-1:0] rd_stage, cond_e cond,
                                logic emit, logic jmp0);
    uword_t w;
    w.op       = op;
    w.stage    = stage;
    w.rd       = rd;
    w.rd_stage = rd_stage;
    w.cond     = cond;
    w.emit     = emit;
    w.jmp0     = jmp0;
    return w;
  endfunction

  // program: take item and fetch stage 0, then multiply (fetching the next
  // stage) and write back for each of the six stages
  function automatic uword_t ucode(logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      4'd0:    w = mk(OP_LOAD, 3'd0, 1'b1, 3'd0, COND_IN,   1'b0, 1'b0);
      4'd1:    w = mk(OP_MUL,  3'd0, 1'b1, 3'd1, COND_NONE, 1'b0, 1'b0);
      4'd2:    w = mk(OP_WB,   3'd0, 1'b0, 3'd0, COND_NONE, 1'b0, 1'b0);
      4'd3:    w = mk(OP_MUL,  3'd1, 1'b1, 3'd2, COND_NONE, 1'b0, 1'b0);
      4'd4:    w = mk(OP_WB,   3'd1, 1'b0, 3'd0, COND_NONE, 1'b0, 1'b0);
      4'd5:    w = mk(OP_MUL,  3'd2, 1'b1, 3'd3, COND_NONE, 1'b0, 1'b0);
      4'd6:    w = mk(OP_WB,   3'd2, 1'b0, 3'd0, COND_NONE, 1'b0, 1'b0);
      4'd7:    w = mk(OP_MUL,  3'd3, 1'b1, 3'd4, COND_NONE, 1'b0, 1'b0);
      4'd8:    w = mk(OP_WB,   3'd3, 1'b0, 3'd0, COND_NONE, 1'b0, 1'b0);
      4'd9:    w = mk(OP_MUL,  3'd4, 1'b1, 3'd5, COND_NONE, 1'b0, 1'b0);
      4'd10:   w = mk(OP_WB,   3'd4, 1'b0, 3'd0, COND_NONE, 1'b0, 1'b0);
      4'd11:   w = mk(OP_MUL,  3'd5, 1'b0, 3'd0, COND_NONE, 1'b0, 1'b0);
      4'd12:   w = mk(OP_WB,   3'd5, 1'b0, 3'd0, COND_OUT,  1'b1, 1'b1);
      default: w = mk(OP_NOP,  3'd0, 1'b0, 3'd0, COND_NONE, 1'b0, 1'b1);
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

>>> rtl/srv_ram.sv
// generic simple dual-port ram, one write port and one registered read port
`default_nettype none
module srv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> rtl/srv_seq.sv
// microcode sequencer: step counter over the program table with wait conditions
`default_nettype none
module srv_seq
  import srv_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire sts_t  sts_i,
  output logic       in_stall_o,
  output ctrl_t      ctrl_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  uword_t          uw;
  logic            go;

  assign uw = ucode(pc_q);

  always_comb begin
    case (uw.cond)
      COND_IN:   go = in_valid_i && !sts_i.clr_busy;
      COND_OUT:  go = sts_i.out_free;
      default:   go = 1'b1;
    endcase
  end

  // stall does not look at valid
  assign in_stall_o = !(uw.op == OP_LOAD && !sts_i.clr_busy);

  always_comb begin
    ctrl_o.load     = go && (uw.op == OP_LOAD);
    ctrl_o.mul      = go && (uw.op == OP_MUL);
    ctrl_o.wb       = go && (uw.op == OP_WB);
    ctrl_o.emit     = go && uw.emit;
    ctrl_o.rd       = go && uw.rd;
    ctrl_o.stage    = uw.stage;
    ctrl_o.rd_stage = uw.rd_stage;
  end

  always_comb begin
    pc_d = pc_q;
    if (go) begin
      pc_d = uw.jmp0 ? '0 : pc_q + PC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/srv_dp.sv
// datapath: delay registers, stage positions, multipliers, rounding, line ram and output register
`default_nettype none
module srv_dp
  import srv_pkg::*;
#(
  parameter int MAX_DELAY = MAX_DELAY_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ctrl_t            ctrl_i,
  input  wire in_item_t         in_item_i,
  input  wire logic             out_stall_i,
  input  wire logic             cfg_we_i,
  input  wire logic [STG_W-1:0] cfg_idx_i,
  input  wire logic [DLY_W-1:0] cfg_data_i,
  output sts_t                  sts_o,
  output logic                  out_valid_o,
  output out_item_t             out_item_o
);

  localparam int DEPTH = NUM_STAGES * MAX_DELAY;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(MAX_DELAY);
  localparam int DW    = $clog2(MAX_DELAY + 1);
  localparam int EW    = (DW > DLY_W) ? DW : DLY_W;

  logic [DLY_W-1:0] dly_q [NUM_STAGES];
  logic [PW-1:0]    pos_q [NUM_STAGES];

  logic [PW-1:0]    p_nxt_q, p_cur_q;
  logic [DW-1:0]    e_nxt_q, e_cur_q;
  logic signed [SMP_W-1:0] x_q;
  logic             last_q, clip_q;
  logic signed [ACC_W-1:0] px_q, pd_q;
  logic             out_valid_q;
  out_item_t        out_q;
  logic             clr_busy_q;
  logic [AW-1:0]    clr_q;

  logic [SMP_W-1:0] rdata;

  // fetch side: clamp the delay and wrap a stale position
  logic [EW-1:0]    d_ext;
  logic [DW-1:0]    e_rd;
  logic [PW-1:0]    p_rd;
  logic [AW-1:0]    raddr;

  always_comb begin
    d_ext = EW'(dly_q[ctrl_i.rd_stage]);
    if (d_ext == '0) begin
      e_rd = DW'(1);
    end else if (d_ext > EW'(MAX_DELAY)) begin
      e_rd = DW'(MAX_DELAY);
    end else begin
      e_rd = DW'(d_ext);
    end
    p_rd  = (DW'(pos_q[ctrl_i.rd_stage]) >= e_rd) ? '0 : pos_q[ctrl_i.rd_stage];
    raddr = AW'(ctrl_i.rd_stage) * AW'(MAX_DELAY) + AW'(p_rd);
  end

  // multiply step
  logic signed [ACC_W:0] px_full, pd_full;
  assign px_full = (ACC_W+1)'($signed({1'b0, gain_x(ctrl_i.stage)})) * (ACC_W+1)'(x_q);
  assign pd_full = (ACC_W+1)'($signed({1'b0, gain_d(ctrl_i.stage)}))
                 * (ACC_W+1)'($signed(rdata));

  // write-back step: truncate toward zero, saturate
  logic signed [ACC_W-1:0] sum, sum_adj;
  logic signed [ACC_W-FRAC_W-1:0] quo;
  logic signed [SMP_W-1:0] y;
  logic             sat;
  logic [DW-1:0]    p_inc;
  logic [PW-1:0]    p_new;
  logic [AW-1:0]    waddr;

  always_comb begin
    sum     = px_q + pd_q;
    sum_adj = sum[ACC_W-1] ? sum + ACC_W'(32'sd32767) : sum;
    quo     = sum_adj[ACC_W-1:FRAC_W];
    if (quo > (ACC_W-FRAC_W)'(32767)) begin
      y   = 16'sh7fff;
      sat = 1'b1;
    end else if (quo < -(ACC_W-FRAC_W)'(32768)) begin
      y   = -16'sh8000;
      sat = 1'b1;
    end else begin
      y   = quo[SMP_W-1:0];
      sat = 1'b0;
    end
    p_inc = DW'(p_cur_q) + DW'(1);
    p_new = (p_inc >= e_cur_q) ? '0 : p_inc[PW-1:0];
    waddr = AW'(ctrl_i.stage) * AW'(MAX_DELAY) + AW'(p_cur_q);
  end

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [SMP_W-1:0] ram_wdata;

  always_comb begin
    if (clr_busy_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = ctrl_i.wb;
      ram_waddr = waddr;
      ram_wdata = y;
    end
  end

  srv_ram #(
    .WIDTH (SMP_W),
    .DEPTH (DEPTH)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ctrl_i.rd),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        dly_q[i] <= dly_reset(STG_W'(i));
        pos_q[i] <= '0;
      end
      clr_busy_q  <= 1'b1;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i < STG_W'(NUM_STAGES))) begin
        dly_q[cfg_idx_i] <= cfg_data_i;
      end
      if (clr_busy_q) begin
        clr_q <= clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (ctrl_i.wb) begin
        pos_q[ctrl_i.stage] <= p_new;
      end
      if (ctrl_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      p_nxt_q <= p_rd;
      e_nxt_q <= e_rd;
    end
    if (ctrl_i.load) begin
      x_q    <= in_item_i.sample_in;
      last_q <= in_item_i.last_in;
      clip_q <= 1'b0;
    end
    if (ctrl_i.mul) begin
      px_q    <= px_full[ACC_W-1:0];
      pd_q    <= pd_full[ACC_W-1:0];
      p_cur_q <= p_nxt_q;
      e_cur_q <= e_nxt_q;
    end
    if (ctrl_i.wb) begin
      x_q    <= y;
      clip_q <= clip_q | sat;
    end
    if (ctrl_i.emit) begin
      out_q.sample_out <= y;
      out_q.clipped    <= clip_q | sat;
      out_q.last_out   <= last_q;
    end
  end

  assign sts_o.clr_busy = clr_busy_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_item_o     = out_q;

endmodule
`default_nettype wire

>>> rtl/schroeder_reverb.sv
// schroeder reverb top level: four comb and two all-pass stages run by a microcoded sequencer
// a result enters the output register at the last write back, once the output slot is free
// one item at a time: the program runs 13 steps per item, two per stage (multiply, write
//   back) plus the load step, set by the shared multiply/round path and the single line ram
// reset: control clears at once, then a clearing pass writes zero to all 6*MAX_DELAY line
//   entries, one a cycle, with input stalled; config writes still go
`default_nettype none
module schroeder_reverb
  import srv_pkg::*;
#(
  parameter int MAX_DELAY = MAX_DELAY_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // input channel
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire in_item_t         in_item_i,
  // output channel
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output out_item_t             out_item_o,
  // delay register writes
  input  wire logic             cfg_we_i,
  input  wire logic [STG_W-1:0] cfg_idx_i,
  input  wire logic [DLY_W-1:0] cfg_data_i
);

  // strobes from the program to the datapath
  ctrl_t ctrl;
  // clearing pass busy and output slot free
  sts_t  sts;

  // step counter walks the program: load, then multiply and write back per stage
  srv_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .ctrl_o     (ctrl)
  );

  // one shared datapath serves all six stages; the next stage's line is fetched
  // while the current one multiplies, so the read never costs a step of its own
  srv_dp #(
    .MAX_DELAY (MAX_DELAY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_item_i   (in_item_i),
    .out_stall_i (out_stall_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire

>>> test/tb_top.sv
// testbench of the schroeder reverb: directed and random samples checked against a built-in predictor
module tb_top
  import srv_pkg::*;
();

  typedef logic [NUM_STAGES-1:0][DLY_W-1:0] delay_set_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_item_t         in_item   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_item;
  logic             cfg_we    = 1'b0;
  logic [STG_W-1:0] cfg_idx   = '0;
  logic [DLY_W-1:0] cfg_data  = '0;

  // predictor state: one circular line per stage, combs first, then all-passes
  logic signed [SMP_W-1:0] echo_mem [NUM_STAGES][MAX_DELAY_DEF];
  logic [DLY_W-1:0]        tap_pos [NUM_STAGES];
  logic [DLY_W-1:0]        delay_len [NUM_STAGES];

  // wet samples still owed by the block, oldest first
  out_item_t   wet_q [$];
  int unsigned mismatches = 0;
  int unsigned rx_hold = 0;
  // no idling on either side while set
  bit          quiet = 1'b0;

  always #5 clk = ~clk;

  schroeder_reverb uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  // runs one dry sample through the six stages and updates the lines
  function automatic out_item_t reverberate(in_item_t it);
    longint           y;
    longint           tap;
    longint           acc;
    longint           g;
    logic [DLY_W-1:0] span;
    logic [DLY_W-1:0] ptr;
    out_item_t        r;
    y = longint'($signed(it.sample_in));
    r = '0;
    for (int k = 0; k < NUM_STAGES; k++) begin
      // zero delay behaves as one, anything past the line length as the full line
      span = delay_len[k];
      if (span == 0) begin
        span = DLY_W'(1);
      end else if (span > DLY_W'(MAX_DELAY_DEF)) begin
        span = DLY_W'(MAX_DELAY_DEF);
      end
      // a stage left beyond a shortened delay starts again at slot zero
      ptr = tap_pos[k];
      if (ptr >= span) begin
        ptr = '0;
      end
      tap = longint'(echo_mem[k][ptr]);
      case (k)
        0:       g = 26378;
        1:       g = 27099;
        2:       g = 25657;
        3:       g = 25035;
        default: g = 22938;
      endcase
      if (k < NUM_COMB) begin
        acc = y * 32768 + g * tap;
      end else begin
        acc = (32768 - g) * y + g * tap;
      end
      // signed division truncates toward zero
      acc = acc / 32768;
      if (acc > 32767) begin
        acc = 32767;
        r.clipped = 1'b1;
      end else if (acc < -32768) begin
        acc = -32768;
        r.clipped = 1'b1;
      end
      echo_mem[k][ptr] = SMP_W'(acc);
      ptr = ptr + 1'b1;
      if (ptr >= span) begin
        ptr = '0;
      end
      tap_pos[k] = ptr;
      y = acc;
    end
    r.sample_out = SMP_W'(y);
    r.last_out   = it.last_in;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= 100) begin
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  // mostly back to back, now and then a short gap, rarely a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // full-scale noise, quiet passages, rail values and loud material
  function automatic logic [SMP_W-1:0] pick_sample();
    logic [SMP_W-1:0] v;
    int unsigned      r;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      v = SMP_W'($urandom());
    end else if (r < 55) begin
      v = SMP_W'($urandom_range(0, 511)) - 16'd256;
    end else if (r < 75) begin
      case ($urandom_range(0, 3))
        0:       v = 16'h7fff;
        1:       v = 16'h8000;
        2:       v = 16'h0000;
        default: v = 16'hffff;
      endcase
    end else begin
      v = {2'b01, 14'($urandom())};
      if ($urandom_range(0, 1) == 1) begin
        v = -v;
      end
    end
    return v;
  endfunction

  function automatic delay_set_t rand_delays(input int unsigned lo, input int unsigned hi);
    delay_set_t d;
    for (int k = 0; k < NUM_STAGES; k++) begin
      d[k] = DLY_W'($urandom_range(lo, hi));
    end
    return d;
  endfunction

  // receiver: random stall windows, changed on the falling edge
  always @(negedge clk) begin
    if (quiet || rx_hold == 0) begin
      out_stall <= 1'b0;
      if (!quiet && $urandom_range(0, 3) == 0) begin
        rx_hold = idle_len();
      end
    end else begin
      out_stall <= 1'b1;
      rx_hold = rx_hold - 1;
    end
  end

  // every accepted wet sample is held against the oldest one owed
  always @(posedge clk) begin : check_wet
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (wet_q.size() == 0) begin
        report_mismatch("sample_out with no item pending",
                        longint'($signed(out_item.sample_out)), longint'(0));
      end else begin
        want = wet_q.pop_front();
        if (out_item.sample_out !== want.sample_out) begin
          report_mismatch("sample_out", longint'($signed(out_item.sample_out)),
                          longint'($signed(want.sample_out)));
        end
        if (out_item.clipped !== want.clipped) begin
          report_mismatch("clipped", longint'(out_item.clipped), longint'(want.clipped));
        end
        if (out_item.last_out !== want.last_out) begin
          report_mismatch("last_out", longint'(out_item.last_out), longint'(want.last_out));
        end
      end
    end
  end

  // offers one item after a random gap, holds it until taken, then predicts it
  task automatic send_sample(input logic [SMP_W-1:0] s, input logic last);
    int unsigned gap;
    in_item_t    it;
    gap = idle_len();
    it.sample_in = s;
    it.last_in   = last;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    wet_q.push_back(reverberate(it));
  endtask

  // lets the block run dry: nothing owed, then a margin past the pipeline latency
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (wet_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // writes all six delays, plus junk to the two unused indexes, which must be dropped
  task automatic set_delays(input delay_set_t d);
    for (int k = 0; k < 8; k++) begin
      @(negedge clk);
      cfg_we  <= 1'b1;
      cfg_idx <= STG_W'(k);
      if (k < NUM_STAGES) begin
        cfg_data     <= d[k];
        delay_len[k] = d[k];
      end else begin
        cfg_data <= DLY_W'($urandom());
      end
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // rail values and bit patterns with the delays as they come out of reset
  task automatic test_reset_values();
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hffff, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h5555, 1'b1);
    send_sample(16'haaaa, 1'b0);
    send_sample(16'h8000, 1'b1);
  endtask

  // one-sample feedback on every stage drives the combs into both rails
  task automatic test_saturation();
    settle();
    set_delays({NUM_STAGES{13'd1}});
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h8000, 1'b1);
  endtask

  // zero, full line, just past it and all ones in the delay registers
  task automatic test_delay_limits();
    settle();
    set_delays({13'd8191, 13'd0, 13'd4097, 13'd4096, 13'd8191, 13'd0});
    send_sample(16'h4000, 1'b0);
    send_sample(16'hc000, 1'b0);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h8001, 1'b1);
  endtask

  // shortening delays below the current positions makes the stages wrap to slot zero
  task automatic test_delay_change();
    settle();
    set_delays({NUM_STAGES{13'd5}});
    send_sample(16'h6000, 1'b0);
    send_sample(16'ha000, 1'b0);
    send_sample(16'h1234, 1'b0);
    settle();
    set_delays({NUM_STAGES{13'd2}});
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h8000, 1'b1);
  endtask

  // phases of random audio under different delay settings
  task automatic test_random_traffic();
    delay_set_t d;
    for (int phase = 0; phase < 6; phase++) begin
      settle();
      case (phase)
        0:       d = rand_delays(1, 8);
        1:       d = rand_delays(1, 64);
        2:       d = rand_delays(1, 16);
        3:       d = rand_delays(0, 8191);
        4: begin
          // register extremes mixed with very short lines
          for (int k = 0; k < NUM_STAGES; k++) begin
            case ($urandom_range(0, 3))
              0:       d[k] = '0;
              1:       d[k] = DLY_W'(MAX_DELAY_DEF);
              2:       d[k] = '1;
              default: d[k] = DLY_W'($urandom_range(1, 3));
            endcase
          end
        end
        default: d = rand_delays(1, 32);
      endcase
      quiet = (phase == 2);
      set_delays(d);
      for (int n = 0; n < 113; n++) begin
        // halfway through the last phase the lines get shorter under the stages
        if (phase == 5 && n == 56) begin
          settle();
          set_delays(rand_delays(1, 4));
        end
        send_sample(pick_sample(), $urandom_range(0, 15) == 0);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      tap_pos[k] = '0;
      for (int j = 0; j < MAX_DELAY_DEF; j++) begin
        echo_mem[k][j] = '0;
      end
    end
    delay_len = '{13'd1309, 13'd793, 13'd1984, 13'd2646, 13'd220, 13'd74};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_saturation();
    test_delay_limits();
    test_delay_change();
    test_random_traffic();

    settle();
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // hang guard, well past the slowest legal run including the line clearing after reset
  initial begin
    #15_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule
